// ----- rtl/tts_pkg.sv -----
`default_nettype none

package tts_pkg;

    // table geometry
    localparam int TIMERS    = 16;
    localparam int TIME_BITS = 48;
    localparam int PERIOD_W  = 32;
    localparam int SLOT_W    = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam int SUM_W     = ((TIME_BITS > PERIOD_W) ? TIME_BITS : PERIOD_W) + 1;

    // command codes
    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_DIST   = 2'd2;

    // one timer slot record
    typedef struct packed {
        logic                 armed;
        logic                 repeating;
        logic [PERIOD_W-1:0]  period;
        logic [TIME_BITS-1:0] deadline;
    } t_slot;

    // per-cell control
    typedef struct packed {
        logic shift;
        logic wr;
        logic clr;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/tts_if.sv -----
`default_nettype none

// command word channel
interface tts_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [3:0]  slot;
    logic [47:0] first_deadline;
    logic [31:0] period;
    logic        repeat_req;
    logic [47:0] current_time;

    modport source (output valid, command, slot, first_deadline, period, repeat_req,
                    current_time, input ready);
    modport sink   (input valid, command, slot, first_deadline, period, repeat_req,
                    current_time, output ready);
endinterface

// result word channel
interface tts_res_if;
    logic       valid;
    logic       ready;
    logic       fired;
    logic [3:0] fired_slot;
    logic       last;

    modport source (output valid, fired, fired_slot, last, input ready);
    modport sink   (input valid, fired, fired_slot, last, output ready);
endinterface

`default_nettype wire

// ----- rtl/timer_table_scheduler_top.sv -----
`default_nettype none

// Timer table scheduler. The slots live in a ring of TIMERS cells; an add or
// remove word writes its slot directly, and a distribute word rotates the ring
// once past a single compare and re-arm unit at cell 0, one slot per cycle
// unless a due slot waits for an earlier fire to leave. A distribute scans in
// the scan state and posts its final result from the done state, which waits
// while the result port holds off; add, remove and unused commands go straight
// to the done state to post their acknowledgement. Fire results come in slot
// order; one finished result may wait in the output register while the next
// word is taken. Reset clears the armed bits at once; no clearing pass.
module timer_table_scheduler_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tts_cmd_if.sink   i_cmd,
    tts_res_if.source o_res
);
    import tts_pkg::*;

    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(TIMERS - 1);

    t_state               r_state, n_state;
    logic [SLOT_W-1:0]    r_idx, n_idx;
    logic [TIME_BITS-1:0] r_now, n_now;
    logic                 r_hold_v, n_hold_v;
    logic [SLOT_W-1:0]    r_hold_slot, n_hold_slot;
    logic                 r_out_v, n_out_v;
    logic                 r_out_fired, n_out_fired;
    logic [3:0]           r_out_slot, n_out_slot;
    logic                 r_out_last, n_out_last;

    logic      w_accept;
    logic      w_out_free;
    logic      w_in_range;
    logic      w_shift, w_wr, w_clr;
    logic      w_head_due;
    t_slot     w_head_rec;
    t_slot     w_wr_data;
    t_slot     w_cell [TIMERS];

    assign i_cmd.ready = (r_state == S_IDLE);
    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign w_out_free  = !r_out_v || o_res.ready;
    assign w_in_range  = (32'(i_cmd.slot) < TIMERS);

    assign w_wr_data = '{armed: 1'b1, repeating: i_cmd.repeat_req,
                         period: i_cmd.period,
                         deadline: TIME_BITS'(i_cmd.first_deadline)};

    // ring of slot cells, rotating toward cell 0
    for (genvar k = 0; k < TIMERS; k++) begin : g_cell
        t_cell_ctl w_ctl;
        t_slot     w_next;

        assign w_ctl.shift = w_shift;
        assign w_ctl.wr    = w_wr && (32'(i_cmd.slot) == k);
        assign w_ctl.clr   = w_clr && (32'(i_cmd.slot) == k);

        if (k == TIMERS - 1) begin : g_tail
            assign w_next = w_head_rec;
        end else begin : g_mid
            assign w_next = w_cell[k + 1];
        end

        tts_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_next    (w_next),
            .i_wr_data (w_wr_data),
            .o_cell    (w_cell[k])
        );
    end

    // compare and re-arm at the head of the ring
    tts_head u_head (
        .i_rec (w_cell[0]),
        .i_now (r_now),
        .o_due (w_head_due),
        .o_rec (w_head_rec)
    );

    // state and payload registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_hold_v <= n_hold_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_now       <= n_now;
        r_hold_slot <= n_hold_slot;
        r_out_fired <= n_out_fired;
        r_out_slot  <= n_out_slot;
        r_out_last  <= n_out_last;
    end

    // sequence commands, scan the ring, post result words
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_now       = r_now;
        n_hold_v    = r_hold_v;
        n_hold_slot = r_hold_slot;
        n_out_v     = r_out_v && !o_res.ready;
        n_out_fired = r_out_fired;
        n_out_slot  = r_out_slot;
        n_out_last  = r_out_last;
        w_shift     = 1'b0;
        w_wr        = 1'b0;
        w_clr       = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_hold_v = 1'b0;
                    case (i_cmd.command)
                        CMD_ADD: begin
                            w_wr    = w_in_range;
                            n_state = S_DONE;
                        end
                        CMD_REMOVE: begin
                            w_clr   = w_in_range;
                            n_state = S_DONE;
                        end
                        CMD_DIST: begin
                            n_now   = TIME_BITS'(i_cmd.current_time);
                            n_idx   = '0;
                            n_state = S_SCAN;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // hold the ring while an earlier fire cannot leave
                if (!(w_head_due && r_hold_v && !w_out_free)) begin
                    w_shift = 1'b1;
                    n_idx   = r_idx + SLOT_W'(1);
                    if (w_head_due) begin
                        if (r_hold_v) begin
                            n_out_v     = 1'b1;
                            n_out_fired = 1'b1;
                            n_out_slot  = 4'(r_hold_slot);
                            n_out_last  = 1'b0;
                        end
                        n_hold_v    = 1'b1;
                        n_hold_slot = r_idx;
                    end
                    if (r_idx == LAST_IDX) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                // post the final fire, or an acknowledgement
                if (w_out_free) begin
                    n_out_v     = 1'b1;
                    n_out_fired = r_hold_v;
                    n_out_slot  = r_hold_v ? 4'(r_hold_slot) : 4'd0;
                    n_out_last  = 1'b1;
                    n_hold_v    = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res.valid      = r_out_v;
    assign o_res.fired      = r_out_fired;
    assign o_res.fired_slot = r_out_slot;
    assign o_res.last       = r_out_last;

    // no pending fire survives into idle
    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !r_hold_v)
        else $error("pending fire left in idle");

    // a distribute starts its scan at slot zero with nothing pending
    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_cmd.command == CMD_DIST |=> r_state == S_SCAN && r_idx == '0
        && !r_hold_v)
        else $error("scan did not start clean");

    // a non-final fire word never waits after the sequence has closed
    a_mid_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.fired && !o_res.last |-> r_state != S_IDLE)
        else $error("non-final fire word outside a distribute");

    // the ring moves only while scanning
    a_shift_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_shift |-> r_state == S_SCAN && !w_wr && !w_clr)
        else $error("ring shifted outside a scan");

endmodule

`default_nettype wire

// ----- rtl/tts_cell.sv -----
`default_nettype none

module tts_cell (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tts_pkg::t_cell_ctl i_ctl,
    input  wire tts_pkg::t_slot     i_next,
    input  wire tts_pkg::t_slot     i_wr_data,
    output tts_pkg::t_slot         o_cell
);
    import tts_pkg::*;

    logic                 r_armed;
    logic                 r_repeating;
    logic [PERIOD_W-1:0]  r_period;
    logic [TIME_BITS-1:0] r_deadline;

    // armed bit: take neighbor on shift, set on add, drop on remove
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b0;
        end else if (i_ctl.shift) begin
            r_armed <= i_next.armed;
        end else if (i_ctl.wr) begin
            r_armed <= 1'b1;
        end else if (i_ctl.clr) begin
            r_armed <= 1'b0;
        end
    end

    // slot body: no reset, written with the armed bit
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_repeating <= i_next.repeating;
            r_period    <= i_next.period;
            r_deadline  <= i_next.deadline;
        end else if (i_ctl.wr) begin
            r_repeating <= i_wr_data.repeating;
            r_period    <= i_wr_data.period;
            r_deadline  <= i_wr_data.deadline;
        end
    end

    assign o_cell = '{armed: r_armed, repeating: r_repeating,
                      period: r_period, deadline: r_deadline};

endmodule

`default_nettype wire

// ----- rtl/tts_head.sv -----
`default_nettype none

module tts_head (
    input  wire tts_pkg::t_slot               i_rec,
    input  wire logic [tts_pkg::TIME_BITS-1:0] i_now,
    output logic                               o_due,
    output tts_pkg::t_slot                    o_rec
);
    import tts_pkg::*;

    logic [SUM_W-1:0]     w_sum;
    logic [TIME_BITS-1:0] w_rearm;

    // compare deadline against current time
    assign o_due = i_rec.armed && (i_rec.deadline <= i_now);

    // re-arm time, saturate at the largest time value
    assign w_sum   = SUM_W'(i_now) + SUM_W'(i_rec.period);
    assign w_rearm = (w_sum[SUM_W-1:TIME_BITS] != '0) ? '1 : w_sum[TIME_BITS-1:0];

    // update a due slot: reload a repeating one, disarm a one-shot
    always_comb begin
        o_rec = i_rec;
        if (o_due) begin
            if (i_rec.repeating) begin
                o_rec.deadline = w_rearm;
            end else begin
                o_rec.armed = 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ----- bench/timer_table_checker.sv -----
// Scoreboard for the timer table. Mirrors the slot table from every accepted
// command word, queues the result words each one causes, and checks every
// accepted result word against the oldest one waiting.
module timer_table_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tts_cmd_if        i_cmd,
    tts_res_if        i_res,
    output int        o_errors,
    output int        o_outstanding
);
    import tts_pkg::*;

    typedef struct packed {
        logic              fired;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } t_res_word;

    // mirrored slot table
    logic                 tbl_armed  [TIMERS];
    logic                 tbl_repeat [TIMERS];
    logic [PERIOD_W-1:0]  tbl_period [TIMERS];
    logic [TIME_BITS-1:0] tbl_due    [TIMERS];

    t_res_word pending_fires[$];
    t_res_word got_word;
    t_res_word want_word;
    int        err_cnt;

    // re-arm at now plus period, pinned to the top of the time range
    function automatic logic [TIME_BITS-1:0] rearm_time(
        input logic [TIME_BITS-1:0] now,
        input logic [PERIOD_W-1:0]  per
    );
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(now) + SUM_W'(per);
        if (sum[SUM_W-1:TIME_BITS] != '0)
            return '1;
        return sum[TIME_BITS-1:0];
    endfunction

    // apply one command word to the table and queue the words it causes
    task automatic advance_table(
        input logic [1:0]           cmd,
        input logic [SLOT_W-1:0]    slot,
        input logic [TIME_BITS-1:0] first_due,
        input logic [PERIOD_W-1:0]  per,
        input logic                 rep,
        input logic [TIME_BITS-1:0] now
    );
        t_res_word w;
        int        fires;
        fires = 0;
        case (cmd)
            CMD_ADD: begin
                if (int'(slot) < TIMERS) begin
                    tbl_armed[slot]  = 1'b1;
                    tbl_due[slot]    = first_due;
                    tbl_period[slot] = per;
                    tbl_repeat[slot] = rep;
                end
            end
            CMD_REMOVE: begin
                if (int'(slot) < TIMERS)
                    tbl_armed[slot] = 1'b0;
            end
            CMD_DIST: begin
                // scan in slot order, fire every armed slot that is due
                for (int i = 0; i < TIMERS; i++) begin
                    if (tbl_armed[i] && tbl_due[i] <= now) begin
                        if (tbl_repeat[i])
                            tbl_due[i] = rearm_time(now, tbl_period[i]);
                        else
                            tbl_armed[i] = 1'b0;
                        w = '{fired: 1'b1, slot: SLOT_W'(i), last: 1'b0};
                        pending_fires = {pending_fires, w};
                        fires++;
                    end
                end
            end
            default: ;
        endcase
        // mark the final fire, or fall back to a bare acknowledgement
        if (fires > 0) begin
            w = pending_fires.pop_back();
            w.last = 1'b1;
        end else
            w = '{fired: 1'b0, slot: '0, last: 1'b1};
        pending_fires = {pending_fires, w};
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TIMERS; i++) begin
                tbl_armed[i]  = 1'b0;
                tbl_repeat[i] = 1'b0;
                tbl_period[i] = '0;
                tbl_due[i]    = '0;
            end
            pending_fires.delete();
            err_cnt = 0;
        end else begin
            // check the result word against the oldest expectation
            if (i_res.valid && i_res.ready) begin
                got_word = '{fired: i_res.fired, slot: i_res.fired_slot, last: i_res.last};
                if (pending_fires.size() == 0) begin
                    $display("%0t: unexpected result word fired=%0d slot=%0d last=%0d",
                             $time, got_word.fired, got_word.slot, got_word.last);
                    err_cnt++;
                end else begin
                    want_word = pending_fires.pop_front();
                    if (got_word !== want_word) begin
                        $display({"%0t: result mismatch: expected fired=%0d slot=%0d ",
                                  "last=%0d, got fired=%0d slot=%0d last=%0d"},
                                 $time, want_word.fired, want_word.slot, want_word.last,
                                 got_word.fired, got_word.slot, got_word.last);
                        err_cnt++;
                    end
                end
            end
            // predict the words this command causes
            if (i_cmd.valid && i_cmd.ready)
                advance_table(i_cmd.command, i_cmd.slot, i_cmd.first_deadline,
                              i_cmd.period, i_cmd.repeat_req, i_cmd.current_time);
        end
        o_errors      <= err_cnt;
        o_outstanding <= pending_fires.size();
    end

endmodule

// ----- bench/testbench.sv -----
module testbench;
    import tts_pkg::*;

    localparam logic [1:0]           CMD_UNUSED  = 2'd3;
    localparam logic [TIME_BITS-1:0] TIME_MAX    = '1;
    localparam int unsigned          CYCLE_LIMIT = 1_000_000;
    localparam int                   TAIL_CYCLES = 40;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 steady_sink = 1'b0;
    bit                   steady_src;
    int                   err_cnt;
    int                   fires_due;
    int unsigned          cycle_cnt = 0;
    int unsigned          stall_left;
    int unsigned          ready_roll;
    logic [TIME_BITS-1:0] t_now;

    tts_cmd_if cmd_if ();
    tts_res_if res_if ();

    timer_table_scheduler_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    timer_table_checker chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd_if),
        .i_res         (res_if),
        .o_errors      (err_cnt),
        .o_outstanding (fires_due)
    );

    always #5 i_clk = ~i_clk;

    // give up on a hung run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side back-pressure: mostly short holds, a few long ones
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_left = 0;
            res_if.ready <= 1'b0;
        end else if (steady_sink) begin
            res_if.ready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left = stall_left - 1;
            res_if.ready <= 1'b0;
        end else begin
            ready_roll = $urandom_range(0, 99);
            if (ready_roll < 65) begin
                res_if.ready <= 1'b1;
            end else begin
                stall_left = (ready_roll < 92) ? $urandom_range(0, 2) : $urandom_range(9, 29);
                res_if.ready <= 1'b0;
            end
        end
    end

    function automatic logic [TIME_BITS-1:0] rand_time();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[TIME_BITS-1:0];
    endfunction

    // hold off a random gap, then present one command word until it is taken
    task automatic send_word(
        input logic [1:0]           cmd,
        input logic [SLOT_W-1:0]    slot,
        input logic [TIME_BITS-1:0] first_due,
        input logic [PERIOD_W-1:0]  per,
        input logic                 rep,
        input logic [TIME_BITS-1:0] now
    );
        int unsigned gap;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (steady_src || roll < 55)
            gap = 0;
        else if (roll < 88)
            gap = $urandom_range(1, 3);
        else if (roll < 97)
            gap = $urandom_range(4, 12);
        else
            gap = $urandom_range(25, 60);
        if (gap != 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid          <= 1'b1;
        cmd_if.command        <= cmd;
        cmd_if.slot           <= slot;
        cmd_if.first_deadline <= first_due;
        cmd_if.period         <= per;
        cmd_if.repeat_req     <= rep;
        cmd_if.current_time   <= now;
        @(posedge i_clk);
        while (cmd_if.ready !== 1'b1)
            @(posedge i_clk);
    endtask

    // drop valid and hold until every expected word has come back
    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        @(posedge i_clk);
        while (fires_due != 0)
            @(posedge i_clk);
    endtask

    initial begin
        logic [1:0]           cmd;
        logic [SLOT_W-1:0]    slot;
        logic [TIME_BITS-1:0] dl;
        logic [TIME_BITS-1:0] now;
        logic [PERIOD_W-1:0]  per;
        logic                 rep;
        int unsigned          roll;
        int unsigned          roll2;

        i_rst_n               = 1'b0;
        steady_src            = 1'b0;
        cmd_if.valid          = 1'b0;
        cmd_if.command        = CMD_ADD;
        cmd_if.slot           = '0;
        cmd_if.first_deadline = '0;
        cmd_if.period         = '0;
        cmd_if.repeat_req     = 1'b0;
        cmd_if.current_time   = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, unused code, remove of an unarmed slot
        send_word(CMD_DIST, SLOT_W'($urandom), rand_time(), $urandom, 1'b1, '0);
        send_word(CMD_UNUSED, SLOT_W'($urandom), rand_time(), $urandom, 1'b1, rand_time());
        send_word(CMD_REMOVE, 4'd5, rand_time(), $urandom, 1'b0, rand_time());
        // zero period repeater, extreme one-shot, then overwrite of an armed slot
        send_word(CMD_ADD, 4'd0, '0, '0, 1'b1, rand_time());
        send_word(CMD_ADD, 4'd15, TIME_MAX, '1, 1'b0, rand_time());
        send_word(CMD_ADD, 4'd7, 48'd100, 32'd10, 1'b0, rand_time());
        send_word(CMD_ADD, 4'd7, 48'd50, 32'd20, 1'b1, rand_time());
        send_word(CMD_DIST, SLOT_W'($urandom), rand_time(), $urandom, 1'b0, '0);
        send_word(CMD_DIST, SLOT_W'($urandom), rand_time(), $urandom, 1'b0, '0);
        send_word(CMD_DIST, SLOT_W'($urandom), rand_time(), $urandom, 1'b0, 48'd49);
        send_word(CMD_DIST, SLOT_W'($urandom), rand_time(), $urandom, 1'b0, 48'd50);
        send_word(CMD_REMOVE, 4'd0, rand_time(), $urandom, 1'b1, rand_time());
        // re-arm past the top of the time range saturates
        send_word(CMD_ADD, 4'd3, TIME_MAX - 48'd5, 32'd100, 1'b1, rand_time());
        send_word(CMD_DIST, SLOT_W'($urandom), rand_time(), $urandom, 1'b1, TIME_MAX - 48'd1);
        send_word(CMD_DIST, SLOT_W'($urandom), rand_time(), $urandom, 1'b1, TIME_MAX);
        send_word(CMD_REMOVE, 4'd3, rand_time(), $urandom, 1'b0, rand_time());
        send_word(CMD_REMOVE, 4'd7, rand_time(), $urandom, 1'b0, rand_time());
        send_word(CMD_DIST, SLOT_W'($urandom), rand_time(), $urandom, 1'b0, TIME_MAX);
        // not yet due, then due exactly at the deadline
        send_word(CMD_ADD, 4'd9, 48'd1000, '0, 1'b0, rand_time());
        send_word(CMD_DIST, SLOT_W'($urandom), rand_time(), $urandom, 1'b1, 48'd999);
        send_word(CMD_DIST, SLOT_W'($urandom), rand_time(), $urandom, 1'b1, 48'd1000);
        send_word(CMD_DIST, SLOT_W'($urandom), rand_time(), $urandom, 1'b1, 48'd1000);
        // largest period on a repeater
        send_word(CMD_ADD, 4'd12, '0, '1, 1'b1, rand_time());
        send_word(CMD_DIST, SLOT_W'($urandom), rand_time(), $urandom, 1'b0, 48'h0000_FFFF_FFFF);
        send_word(CMD_REMOVE, 4'd12, rand_time(), $urandom, 1'b0, rand_time());
        wait_drained();

        // random phases: low, scattered and top-of-range time bases
        for (int ph = 0; ph < 6; ph++) begin
            steady_src = (ph == 2);
            steady_sink <= (ph == 2);
            case (ph % 3)
                0:       t_now = '0;
                1:       t_now = rand_time();
                default: t_now = TIME_MAX - 48'd600;
            endcase

            // arm every slot as already due, then fire them all in one scan
            if (ph == 1 || ph == 5) begin
                for (int s = 0; s < TIMERS; s++)
                    send_word(CMD_ADD, SLOT_W'(s), t_now - $urandom_range(0, 7),
                              $urandom_range(0, 40), 1'($urandom), rand_time());
                send_word(CMD_DIST, SLOT_W'($urandom), rand_time(), $urandom, 1'($urandom),
                          t_now);
            end

            for (int k = 0; k < 35; k++) begin
                roll  = $urandom_range(0, 99);
                roll2 = $urandom_range(0, 99);
                slot  = SLOT_W'($urandom);
                dl    = rand_time();
                per   = $urandom;
                rep   = 1'($urandom);
                now   = rand_time();
                if (roll < 35) begin
                    cmd = CMD_ADD;
                    if (roll2 < 65)
                        dl = t_now + $urandom_range(1, 60);
                    else if (roll2 < 85)
                        dl = t_now - $urandom_range(0, 20);
                    roll2 = $urandom_range(0, 99);
                    if (roll2 < 55)
                        per = $urandom_range(0, 40);
                    else if (roll2 < 75)
                        per = '0;
                    else if (roll2 >= 93)
                        per = '1;
                end else if (roll < 45) begin
                    cmd = CMD_REMOVE;
                end else if (roll < 94) begin
                    cmd = CMD_DIST;
                    if (roll2 < 88) begin
                        t_now = t_now + $urandom_range(0, 40);
                        now   = t_now;
                    end else if (roll2 >= 94) begin
                        now = TIME_MAX;
                    end
                end else begin
                    cmd = CMD_UNUSED;
                end
                send_word(cmd, slot, dl, per, rep, now);
            end
            wait_drained();
        end

        steady_sink <= 1'b0;
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_cnt == 0 && fires_due == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
